/* sv/cascaded_attitude_pid_core_macros.svh */
// Assertion macros shared by the cascaded attitude PID RTL.
// Included by the modules that carry concurrent assertions.
`ifndef CASCADED_ATTITUDE_PID_CORE_MACROS_SVH
`define CASCADED_ATTITUDE_PID_CORE_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CAP_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// Next-cycle implication checked outside reset.
`define CAP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

/* sv/cap_pkg.sv */
// Shared types and constants of the cascaded attitude PID core.
// No dependencies.
`timescale 1ns / 1ps
package cap_pkg;
  localparam int unsigned NumRegs = 8;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned DriveW = 24;
  localparam int unsigned AccW = 48;
  localparam int unsigned OpW = 34;

  typedef enum logic [CfgIdxW-1:0] {
    RegPGain = 3'd0, RegIGain = 3'd1, RegDGain = 3'd2, RegPitchSp = 3'd3,
    RegAirSp = 3'd4, RegAirThr = 3'd5, RegAttLim = 3'd6, RegAirLim = 3'd7
  } reg_idx_e;

  // Start request to the serial multiplier.
  typedef struct packed {
    logic                  start;
    logic signed [15:0]    mcand;
    logic signed [OpW-1:0] mplier;
  } mul_req_t;

  localparam logic signed [15:0] PitchSpReset = -16'sd1280;
  localparam logic signed [15:0] AirSpReset = 16'sd3840;
  localparam logic [14:0] AirThrReset = 15'd1024;
  localparam logic [15:0] AttLimReset = 16'd32000;
  localparam logic [15:0] AirLimReset = 16'd256;
endpackage

/* sv/cap_serial_mul.sv */
// Bit-serial signed multiplier: 16-bit multiplicand by a signed multiplier.
// Uses cap_pkg; one multiplier bit per cycle, all OpW bits per product.
`timescale 1ns / 1ps
module cap_serial_mul
  import cap_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mul_req_t              req_i,
  output logic                  done_o,
  output logic signed [AccW-1:0] prod_o
);
  localparam int unsigned CntW = $clog2(OpW + 1);

  logic                   busy_q, busy_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic signed [OpW-1:0]  mpl_q, mpl_d;
  logic signed [AccW-1:0] mcd_q, mcd_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic                   done_q, done_d;

  // Shift-and-add; the top multiplier bit has negative weight.
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    mpl_d  = mpl_q;
    mcd_d  = mcd_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mpl_d  = req_i.mplier;
      mcd_d  = AccW'(req_i.mcand);
      acc_d  = '0;
    end else if (busy_q) begin
      if (mpl_q[0]) begin
        if (cnt_q == CntW'(OpW - 1)) acc_d = acc_q - mcd_q;
        else acc_d = acc_q + mcd_q;
      end
      mpl_d = mpl_q >>> 1;
      mcd_d = mcd_q <<< 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(OpW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mpl_q <= mpl_d;
    mcd_q <= mcd_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;
endmodule

/* sv/cascaded_attitude_pid_core.sv */
// Cascaded attitude PID core: top level with sequencer and state.
// Uses cap_pkg, cap_serial_mul and the assertion macro header.
//
// Usage: one sensor sample enters on the in channel (in_valid_i/in_stall_o)
// and one result with three drives and pitot_active leaves on the out
// channel (out_valid_o/out_stall_i). Each channel accepts an item at an
// edge where valid is high and stall low.
// One item runs 3 PID lanes, or 4 when the airspeed loop is active. Each
// lane takes three products (P, I, then D) from a single bit-serial
// multiplier, then a finishing state. The result becomes valid after the
// finishing state of the last lane, and the next item is accepted only
// once the result has been taken and the sequencer is back in idle, so
// the shared serial multiplier bounds the item rate.
// The result sits in an output register; while the receiver stalls it holds
// and the block does not take a new item until it has been taken.
// Reset clears integrators and smoothing history, loads register defaults
// and sets the pitch target to the pitch setpoint. Configuration is written
// through cfg_we_i/cfg_idx_i/cfg_data_i; the user must write it only while
// the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
`include "cascaded_attitude_pid_core_macros.svh"
module cascaded_attitude_pid_core
  import cap_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 pitot_en_i,
  input  logic signed [15:0]   pitch_angle_i,
  input  logic signed [15:0]   pitch_rate_i,
  input  logic signed [15:0]   roll_angle_i,
  input  logic signed [15:0]   roll_rate_i,
  input  logic signed [15:0]   yaw_angle_i,
  input  logic signed [15:0]   yaw_rate_i,
  input  logic signed [15:0]   measured_airspeed_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic signed [23:0]   pitch_drive_o,
  output logic signed [23:0]   roll_drive_o,
  output logic signed [23:0]   yaw_drive_o,
  output logic                 pitot_active_o
);
  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StMulP = 3'd1;
  localparam logic [2:0] StMulI = 3'd2;
  localparam logic [2:0] StMulD = 3'd3;
  localparam logic [2:0] StFin  = 3'd4;
  localparam logic [2:0] StOut  = 3'd5;

  // Configuration registers.
  logic [63:0]        pg_q, ig_q, dg_q;
  logic signed [15:0] psp_q, asp_q;
  logic [14:0]        thr_q;
  logic [15:0]        alim_q, slim_q;

  // Controller state.
  logic signed [31:0]       integ_q [4];
  logic signed [DriveW-1:0] prev_q [3];
  logic signed [DriveW-1:0] tgt_q;

  // Sequencer state and captured sample.
  logic [2:0]          st_q, st_d;
  logic [1:0]          lane_q, lane_d;
  logic                pitot_q;
  logic                active_q;
  logic signed [15:0]  ang_q [3];
  logic signed [15:0]  rate_q [3];
  logic signed [15:0]  air_q;
  logic signed [AccW-1:0] sum_q;
  logic signed [DriveW-1:0] drv_q [3];
  logic                out_valid_q;

  mul_req_t               mreq, mreq_k;
  logic                   mdone;
  logic signed [AccW-1:0] mprod;

  cap_serial_mul u_mul (
    .clk_i (clk_i), .rst_ni(rst_ni), .req_i(mreq_k), .done_o(mdone), .prod_o(mprod)
  );

  // Lane operands.
  logic signed [15:0] pg_l, ig_l, dg_l;
  logic signed [OpW-1:0] err_l;
  logic signed [15:0] rate_l;
  logic [15:0] lim_l;
  always_comb begin
    pg_l   = pg_q[16*lane_q +: 16];
    ig_l   = ig_q[16*lane_q +: 16];
    dg_l   = dg_q[16*lane_q +: 16];
    lim_l  = (lane_q == 2'd3) ? slim_q : alim_q;
    rate_l = (lane_q == 2'd3) ? 16'sd0 : rate_q[lane_q];
    if (lane_q == 2'd3) err_l = OpW'(asp_q) - OpW'(air_q);
    else if (lane_q == 2'd0) err_l = OpW'(tgt_q) - OpW'(ang_q[0]);
    else err_l = -OpW'(ang_q[lane_q]);
  end

  // Integrator step and clamp from the I product.
  logic signed [AccW-1:0] int_new, lim_w;
  logic signed [31:0]     int_clamped;
  always_comb begin
    lim_w   = AccW'({1'b0, lim_l, 8'd0});
    int_new = AccW'(integ_q[lane_q]) + (mprod >>> 8);
    if (int_new > lim_w) int_clamped = 32'(lim_w);
    else if (int_new < -lim_w) int_clamped = 32'(-lim_w);
    else int_clamped = int_new[31:0];
  end

  // Raw drive, saturation and smoothing.
  logic signed [AccW-1:0]   acc_sh;
  logic signed [DriveW-1:0] raw_sat;
  logic signed [DriveW+2:0] smooth;
  always_comb begin
    acc_sh = (sum_q + (mprod <<< 2)) >>> 8;
    if (acc_sh > AccW'(24'sh7FFFFF)) raw_sat = 24'sh7FFFFF;
    else if (acc_sh < -AccW'(25'sh800000)) raw_sat = 24'sh800000;
    else raw_sat = acc_sh[DriveW-1:0];
    smooth = ((DriveW+3)'(raw_sat) + (DriveW+3)'(3) * (DriveW+3)'(prev_q[lane_q[1:0] == 2'd3 ?
              2'd0 : lane_q])) >>> 2;
  end

  logic take_in;
  assign take_in = in_valid_i && !in_stall_o;
  assign in_stall_o = (st_q != StIdle);
  logic take_out;
  assign take_out = out_valid_q && !out_stall_i;
  logic airfast;
  assign airfast = measured_airspeed_i > $signed({1'b0, thr_q});

  // Multiplier requests for the I and D products, issued as the previous product completes.
  always_comb begin
    mreq.start  = 1'b0;
    mreq.mcand  = pg_l;
    mreq.mplier = err_l;
    st_d   = st_q;
    lane_d = lane_q;
    unique case (st_q)
      StIdle: if (take_in) begin
        st_d = StMulP;
        lane_d = (pitot_en_i && airfast) ? 2'd3 : 2'd0;
      end
      StMulP: if (mdone) begin
        st_d = StMulI;
        mreq.start = 1'b1; mreq.mcand = ig_l; mreq.mplier = err_l;
      end
      StMulI: if (mdone) begin
        st_d = StMulD;
        mreq.start = 1'b1; mreq.mcand = dg_l; mreq.mplier = OpW'(rate_l);
      end
      StMulD: if (mdone) st_d = StFin;
      StFin: begin
        if (lane_q == 2'd2) st_d = StOut;
        else begin
          st_d = StMulP;
          lane_d = (lane_q == 2'd3) ? 2'd0 : lane_q + 2'd1;
        end
      end
      StOut: if (!out_valid_q) st_d = StIdle;
      default: st_d = StIdle;
    endcase
    // No request is made from idle; the kick starts the first product of a fresh item.
    if (st_q == StIdle && take_in) mreq.start = 1'b0;
  end

  // A one-cycle kick starts the P product of each lane once its operands are set.
  logic kick_q;
  always_comb begin
    mreq_k = mreq;
    if (kick_q) begin
      mreq_k.start = 1'b1; mreq_k.mcand = pg_l; mreq_k.mplier = err_l;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StIdle;
      lane_q <= 2'd0;
      kick_q <= 1'b0;
      out_valid_q <= 1'b0;
      pg_q <= '0; ig_q <= '0; dg_q <= '0;
      psp_q <= PitchSpReset; asp_q <= AirSpReset; thr_q <= AirThrReset;
      alim_q <= AttLimReset; slim_q <= AirLimReset;
      for (int k = 0; k < 4; k++) integ_q[k] <= '0;
      for (int k = 0; k < 3; k++) prev_q[k] <= '0;
      tgt_q <= DriveW'(PitchSpReset);
    end else begin
      st_q <= st_d;
      lane_q <= lane_d;
      kick_q <= ((st_q == StIdle) && take_in) || ((st_q == StFin) && (lane_q != 2'd2));
      if (take_out) out_valid_q <= 1'b0;
      if (cfg_we_i) begin
        unique case (reg_idx_e'(cfg_idx_i))
          RegPGain: pg_q <= cfg_data_i;
          RegIGain: ig_q <= cfg_data_i;
          RegDGain: dg_q <= cfg_data_i;
          RegPitchSp: begin
            psp_q <= cfg_data_i[15:0];
            tgt_q <= DriveW'($signed(cfg_data_i[15:0]));
          end
          RegAirSp: asp_q <= cfg_data_i[15:0];
          RegAirThr: thr_q <= cfg_data_i[14:0];
          RegAttLim: alim_q <= cfg_data_i[15:0];
          RegAirLim: slim_q <= cfg_data_i[15:0];
          default: ;
        endcase
      end
      if (take_in && pitot_en_i && !airfast) tgt_q <= DriveW'(psp_q);
      if (st_q == StMulI && mdone) integ_q[lane_q] <= int_clamped;
      if (st_q == StFin) begin
        if (lane_q == 2'd3) tgt_q <= raw_sat;
        else prev_q[lane_q] <= smooth[DriveW-1:0];
        if (lane_q == 2'd2) out_valid_q <= 1'b1;
      end
    end
  end

  // Sample capture, partial sums and output drives.
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      pitot_q <= pitot_en_i;
      active_q <= pitot_en_i && airfast;
      ang_q[0] <= pitch_angle_i; rate_q[0] <= pitch_rate_i;
      ang_q[1] <= roll_angle_i;  rate_q[1] <= roll_rate_i;
      ang_q[2] <= yaw_angle_i;   rate_q[2] <= yaw_rate_i;
      air_q <= measured_airspeed_i;
    end
    if (st_q == StMulP && mdone) sum_q <= mprod;
    if (st_q == StMulI && mdone) sum_q <= sum_q + AccW'(int_clamped);
    if (st_q == StFin && lane_q != 2'd3) drv_q[lane_q] <= smooth[DriveW-1:0];
  end

  // The FSM feeds the multiplier; the kick covers each P product.
  assign pitch_drive_o = drv_q[0];
  assign roll_drive_o = drv_q[1];
  assign yaw_drive_o = drv_q[2];
  assign pitot_active_o = active_q;
  assign out_valid_o = out_valid_q;

  `CAP_ASSERT_IMPL(a_busy_stall, clk_i, rst_ni, st_q != StIdle, in_stall_o)
  `CAP_ASSERT_IMPL(a_valid_busy, clk_i, rst_ni, out_valid_q, st_q != StIdle)
  `CAP_ASSERT_NEXT(a_fin_valid, clk_i, rst_ni, st_q == StFin && lane_q == 2'd2,
                   out_valid_q)
  `CAP_ASSERT_IMPL(a_pitot, clk_i, rst_ni, out_valid_q && active_q, pitot_q)
endmodule

/* tb/cascaded_attitude_pid_checker.sv */
// Checker for the cascaded attitude PID core: watches the configuration port and
// both item channels, predicts every result and compares it field by field.
// Depends on cap_pkg for the register indexes and port widths.
`timescale 1ns / 1ps
module cascaded_attitude_pid_checker
  import cap_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  logic                pitot_en_i,
  input  logic signed [15:0]  pitch_angle_i,
  input  logic signed [15:0]  pitch_rate_i,
  input  logic signed [15:0]  roll_angle_i,
  input  logic signed [15:0]  roll_rate_i,
  input  logic signed [15:0]  yaw_angle_i,
  input  logic signed [15:0]  yaw_rate_i,
  input  logic signed [15:0]  measured_airspeed_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  logic signed [23:0]  pitch_drive_i,
  input  logic signed [23:0]  roll_drive_i,
  input  logic signed [23:0]  yaw_drive_i,
  input  logic                pitot_active_i,
  output int                  fail_count_o,
  output int                  pending_count_o,
  output int                  sample_count_o,
  output int                  pitot_count_o
);

  typedef struct {
    logic signed [23:0] pitch;
    logic signed [23:0] roll;
    logic signed [23:0] yaw;
    logic               active;
  } drive_set_t;

  localparam longint DriveMax = 64'sd8388607;
  localparam longint DriveMin = -64'sd8388608;

  // Shadow copy of the configuration and of the controller state.
  logic [63:0]        p_gains, i_gains, d_gains;
  logic signed [15:0] pitch_sp, air_sp;
  logic [14:0]        air_thr;
  logic [15:0]        att_lim, air_lim;
  longint             integ [4];
  longint             prev_drive [3];
  longint             pitch_target;
  drive_set_t         expected_drives [$];

  assign pending_count_o = expected_drives.size();

  function automatic longint gain_of(logic [63:0] lanes, int k);
    return longint'($signed(lanes[16*k +: 16]));
  endfunction

  function automatic longint clamp24(longint v);
    if (v > DriveMax) return DriveMax;
    if (v < DriveMin) return DriveMin;
    return v;
  endfunction

  // One PID lane: integrate, clamp the integrator, then form the raw drive.
  function automatic longint pid_lane(int k, longint err, longint rate, logic [15:0] lim_q);
    longint lim;
    longint acc;
    lim = longint'(lim_q) * 256;
    integ[k] += (gain_of(i_gains, k) * err) >>> 8;
    if (integ[k] > lim) integ[k] = lim;
    if (integ[k] < -lim) integ[k] = -lim;
    acc = gain_of(p_gains, k) * err + gain_of(d_gains, k) * rate * 4 + integ[k];
    return clamp24(acc >>> 8);
  endfunction

  // Runs the whole controller for one sensor sample.
  function automatic drive_set_t predict_drives(logic pitot, longint air,
                                                longint ang [3], longint rate [3]);
    drive_set_t d;
    longint     raw;
    longint     tgt;
    longint     sm [3];
    d.active = pitot && (air > longint'(air_thr));
    if (pitot) begin
      if (d.active) begin
        pitch_target = pid_lane(3, longint'(air_sp) - air, 0, air_lim);
      end else begin
        pitch_target = longint'(pitch_sp);
      end
    end
    for (int a = 0; a < 3; a++) begin
      tgt = (a == 0) ? pitch_target : 0;
      raw = pid_lane(a, tgt - ang[a], rate[a], att_lim);
      sm[a] = (raw + 3 * prev_drive[a]) >>> 2;
      prev_drive[a] = sm[a];
    end
    d.pitch = sm[0][23:0];
    d.roll = sm[1][23:0];
    d.yaw = sm[2][23:0];
    return d;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    longint     ang [3];
    longint     rate [3];
    drive_set_t got;
    drive_set_t want;
    if (!rst_ni) begin
      p_gains = '0;
      i_gains = '0;
      d_gains = '0;
      pitch_sp = PitchSpReset;
      air_sp = AirSpReset;
      air_thr = AirThrReset;
      att_lim = AttLimReset;
      air_lim = AirLimReset;
      integ = '{default: 0};
      prev_drive = '{default: 0};
      pitch_target = longint'(PitchSpReset);
      expected_drives.delete();
      fail_count_o = 0;
      sample_count_o = 0;
      pitot_count_o = 0;
    end else begin
      // Configuration writes update the shadow registers.
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          RegPGain: p_gains = cfg_data_i;
          RegIGain: i_gains = cfg_data_i;
          RegDGain: d_gains = cfg_data_i;
          RegPitchSp: begin
            pitch_sp = cfg_data_i[15:0];
            pitch_target = longint'(pitch_sp);
          end
          RegAirSp: air_sp = cfg_data_i[15:0];
          RegAirThr: air_thr = cfg_data_i[14:0];
          RegAttLim: att_lim = cfg_data_i[15:0];
          RegAirLim: air_lim = cfg_data_i[15:0];
          default: ;
        endcase
      end
      // An accepted result is compared with the oldest prediction.
      if (out_valid_i && !out_stall_i) begin
        got = '{pitch_drive_i, roll_drive_i, yaw_drive_i, pitot_active_i};
        if (expected_drives.size() == 0) begin
          $display("%0t: result item arrived with no prediction waiting", $time);
          fail_count_o++;
        end else begin
          want = expected_drives.pop_front();
          if (got.pitch !== want.pitch) report_mismatch("pitch_drive", got.pitch, want.pitch);
          if (got.roll !== want.roll) report_mismatch("roll_drive", got.roll, want.roll);
          if (got.yaw !== want.yaw) report_mismatch("yaw_drive", got.yaw, want.yaw);
          if (got.active !== want.active) begin
            report_mismatch("pitot_active", got.active, want.active);
          end
        end
      end
      // An accepted sensor item yields one prediction.
      if (in_valid_i && !in_stall_i) begin
        ang = '{pitch_angle_i, roll_angle_i, yaw_angle_i};
        rate = '{pitch_rate_i, roll_rate_i, yaw_rate_i};
        want = predict_drives(pitot_en_i, longint'(measured_airspeed_i), ang, rate);
        expected_drives.push_back(want);
        sample_count_o++;
        if (want.active) pitot_count_o++;
      end
    end
  end

endmodule

/* tb/cascaded_attitude_pid_core_tb.sv */
// Testbench top for the cascaded attitude PID core: clock, reset, stimulus,
// idling phases, watchdog and verdict. Depends on cap_pkg, the core and
// cascaded_attitude_pid_checker.
`timescale 1ns / 1ps
module cascaded_attitude_pid_core_tb;
  import cap_pkg::*;

  localparam int IdleLimit = 20000;
  localparam int DrainCycles = 600;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  logic                in_valid, in_stall;
  logic                pitot_en;
  logic signed [15:0]  pitch_angle, pitch_rate, roll_angle, roll_rate;
  logic signed [15:0]  yaw_angle, yaw_rate, airspeed;
  logic                out_valid, out_stall;
  logic signed [23:0]  pitch_drive, roll_drive, yaw_drive;
  logic                pitot_active;
  int                  fail_count, pending_count, sample_count, pitot_count;
  int                  idle_mode;
  int                  quiet_cycles;

  cascaded_attitude_pid_core dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .pitot_en_i(pitot_en),
    .pitch_angle_i(pitch_angle), .pitch_rate_i(pitch_rate),
    .roll_angle_i(roll_angle), .roll_rate_i(roll_rate),
    .yaw_angle_i(yaw_angle), .yaw_rate_i(yaw_rate),
    .measured_airspeed_i(airspeed),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .pitch_drive_o(pitch_drive), .roll_drive_o(roll_drive),
    .yaw_drive_o(yaw_drive), .pitot_active_o(pitot_active)
  );

  cascaded_attitude_pid_checker checker_i (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .pitot_en_i(pitot_en),
    .pitch_angle_i(pitch_angle), .pitch_rate_i(pitch_rate),
    .roll_angle_i(roll_angle), .roll_rate_i(roll_rate),
    .yaw_angle_i(yaw_angle), .yaw_rate_i(yaw_rate),
    .measured_airspeed_i(airspeed),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .pitch_drive_i(pitch_drive), .roll_drive_i(roll_drive),
    .yaw_drive_i(yaw_drive), .pitot_active_i(pitot_active),
    .fail_count_o(fail_count), .pending_count_o(pending_count),
    .sample_count_o(sample_count), .pitot_count_o(pitot_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls according to the current idling phase.
  always @(negedge clk) begin
    if (idle_mode == 2) begin
      out_stall <= ($urandom_range(99) < 82);
    end else if (idle_mode == 3) begin
      out_stall <= ($urandom_range(99) < 33);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles without any accepted item on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("watchdog expired after %0d quiet cycles", IdleLimit);
      $display("cascaded_attitude_pid_core regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Small or full-range signed sample value.
  function automatic logic signed [15:0] sample16();
    if ($urandom_range(1)) return 16'($urandom);
    return 16'($signed($urandom_range(2048)) - 1024);
  endfunction

  // Four gain lanes, either modest or anything at all.
  function automatic logic [63:0] gain_lanes(bit modest);
    logic [63:0] v;
    for (int k = 0; k < 4; k++) begin
      v[16*k +: 16] = modest ? 16'($signed($urandom_range(1024)) - 512) : 16'($urandom);
    end
    return v;
  endfunction

  task automatic write_reg(reg_idx_e idx, logic [63:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Lets the block drain before the configuration changes.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic configure(logic [63:0] p, logic [63:0] i, logic [63:0] d,
                           logic [15:0] psp, logic [15:0] asp, logic [14:0] thr,
                           logic [15:0] alim, logic [15:0] slim);
    logic [63:0] junk;
    wait_idle();
    junk = {$urandom, $urandom};
    write_reg(RegPGain, p);
    write_reg(RegIGain, i);
    write_reg(RegDGain, d);
    // Upper bits of narrow registers carry noise that must be dropped.
    write_reg(RegPitchSp, {junk[63:16], psp});
    write_reg(RegAirSp, {junk[63:16], asp});
    write_reg(RegAirThr, {junk[63:15], thr});
    write_reg(RegAttLim, {junk[63:16], alim});
    write_reg(RegAirLim, {junk[63:16], slim});
  endtask

  // Drives one sensor item and holds it until it is accepted.
  task automatic send_sample(logic pitot, logic signed [15:0] pa, logic signed [15:0] pr,
                             logic signed [15:0] ra, logic signed [15:0] rr,
                             logic signed [15:0] ya, logic signed [15:0] yr,
                             logic signed [15:0] air);
    logic stalled;
    if ((idle_mode == 1 && $urandom_range(99) < 82) ||
        (idle_mode == 3 && $urandom_range(99) < 33)) begin
      in_valid <= 1'b0;
      do begin
        @(negedge clk);
      end while ((idle_mode == 1 && $urandom_range(99) < 82) ||
                 (idle_mode == 3 && $urandom_range(99) < 33));
    end
    in_valid <= 1'b1;
    pitot_en <= pitot;
    pitch_angle <= pa;
    pitch_rate <= pr;
    roll_angle <= ra;
    roll_rate <= rr;
    yaw_angle <= ya;
    yaw_rate <= yr;
    airspeed <= air;
    // The stall seen now decides the coming rising edge.
    do begin
      stalled = in_stall;
      @(negedge clk);
    end while (stalled);
  endtask

  // Sensor item with random content; airspeed is often near the threshold.
  task automatic send_random(logic [14:0] thr);
    logic signed [15:0] air;
    case ($urandom_range(3))
      0: air = 16'($urandom);
      1: air = 16'($signed({1'b0, thr}) + $signed($urandom_range(8)) - 4);
      default: air = 16'($signed({1'b0, thr}) + $signed($urandom_range(2000)) - 1000);
    endcase
    send_sample($urandom_range(99) < 70, sample16(), sample16(), sample16(), sample16(),
                sample16(), sample16(), air);
  endtask

  initial begin
    logic [14:0] thr;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = RegPGain;
    cfg_data = '0;
    in_valid = 1'b0;
    pitot_en = 1'b0;
    {pitch_angle, pitch_rate, roll_angle, roll_rate} = '0;
    {yaw_angle, yaw_rate, airspeed} = '0;
    idle_mode = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed items under reset defaults, then under modest gains.
    send_sample(1'b1, 16'sd100, 16'sd10, -16'sd50, 16'sd5, 16'sd7, -16'sd3, 16'sd2000);
    configure(gain_lanes(1), gain_lanes(1), gain_lanes(1), -16'sd1280, 16'sd3840,
              15'd1024, 16'd32000, 16'd256);
    send_sample(1'b0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_sample(1'b0, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff,
                16'sh7fff);
    send_sample(1'b0, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768,
                -16'sd32768, -16'sd32768);
    // Fast pitot, then pitot off keeping the outer target, then slow pitot.
    send_sample(1'b1, 16'sd300, 16'sd20, 16'sd10, -16'sd20, 16'sd0, 16'sd4, 16'sd3000);
    send_sample(1'b1, 16'sd200, -16'sd20, 16'sd10, 16'sd20, -16'sd9, 16'sd4, 16'sd5000);
    send_sample(1'b0, 16'sd200, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd5000);
    send_sample(1'b1, 16'sd200, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1024);
    send_sample(1'b1, 16'sd200, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1025);
    send_sample(1'b1, 16'sd200, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, -16'sd32768);
    send_sample(1'b0, 16'sd200, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd1, 16'sd9000);
    // Integrator wind-up toward the clamp.
    repeat (8) send_sample(1'b1, 16'sh7fff, 16'sd0, -16'sd32768, 16'sd0, 16'sh7fff, 16'sd0,
                           16'sh7fff);

    // Random phases over several configurations, extremes among them.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: configure(gain_lanes(1), gain_lanes(1), gain_lanes(1), 16'($urandom),
                     16'($urandom), 15'd1024, 16'd32000, 16'd256);
        1: configure({4{16'h7fff}}, {4{16'h7fff}}, {4{16'h7fff}}, 16'h7fff, 16'h7fff,
                     15'd0, 16'hffff, 16'hffff);
        2: configure({4{16'h8000}}, {4{16'h8000}}, {4{16'h8000}}, 16'h8000, 16'h8000,
                     15'h7fff, 16'd0, 16'd0);
        3: configure(gain_lanes(1), gain_lanes(1), gain_lanes(1), 16'($urandom),
                     16'($urandom), 15'($urandom), 16'($urandom), 16'($urandom));
        default: configure({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                           16'($urandom), 16'($urandom), 15'($urandom), 16'($urandom),
                           16'($urandom));
      endcase
      thr = checker_port_thr(phase);
      for (int n = 0; n < 164; n++) begin
        if (n % 41 == 0) idle_mode = ($urandom_range(3) + n / 41 + phase) % 4;
        send_random(thr);
      end
    end

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    $display("covered %0d sensor items, %0d with the airspeed loop active,", sample_count,
             pitot_count);
    $display("over six register settings and four idling patterns");
    if (fail_count == 0 && pending_count == 0) begin
      $display("cascaded_attitude_pid_core regression: pass");
    end else begin
      $display("cascaded_attitude_pid_core regression: fail");
    end
    $finish;
  end

  // Threshold now in effect, mirrored from the last configuration write.
  function automatic logic [14:0] checker_port_thr(int phase);
    return checker_i.air_thr;
  endfunction

endmodule
